// ===== rtl/esv_pkg.sv =====
// Shared types and constants for the ElGamal signature engine.
`default_nettype none
package esv_pkg;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS   = 2'd0,
        REG_GENERATOR = 2'd1,
        REG_PRIVATE   = 2'd2,
        REG_PUBLIC    = 2'd3
    } cfg_reg_t;

    localparam logic OP_SIGN   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // Request to the modular arithmetic unit.
    typedef enum logic [1:0] {
        MU_MUL = 2'd0,
        MU_RED = 2'd1,
        MU_DIV = 2'd2
    } mu_op_t;
endpackage
`default_nettype wire

// ===== rtl/esv_modmul.sv =====
// Bit-serial modular multiplier, reducer and divider shared by the engine.
`default_nettype none
module esv_modmul #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire esv_pkg::mu_op_t   op,
    input  wire logic [WIDTH-1:0]  opa,
    input  wire logic [WIDTH-1:0]  opb,
    input  wire logic [WIDTH-1:0]  modulus,
    output logic                   done,
    output logic [WIDTH-1:0]       result,
    output logic [WIDTH-1:0]       remainder
);
    import esv_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH + 1);

    // MU_MUL: result = opa*opb mod modulus (both operands below modulus),
    //         MSB-first double-and-add over opb.
    // MU_RED: remainder = opb mod modulus, result = opb / modulus (restoring).
    // MU_DIV: same as MU_RED; kept for readability of callers.
    logic             busy_reg;
    mu_op_t           op_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH:0]   acc_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] q_reg;

    logic [WIDTH+1:0] dbl;
    logic [WIDTH+1:0] dbl_add;
    logic [WIDTH+1:0] step1;
    logic [WIDTH+1:0] step2;
    logic [WIDTH:0]   rsh;
    logic             rge;

    always_comb begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {2'b00, m_reg}) begin
            step1 = dbl - {2'b00, m_reg};
        end else begin
            step1 = dbl;
        end
        dbl_add = step1 + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        if (dbl_add >= {2'b00, m_reg}) begin
            step2 = dbl_add - {2'b00, m_reg};
        end else begin
            step2 = dbl_add;
        end
        rsh = {acc_reg[WIDTH-1:0], b_reg[WIDTH-1]};
        rge = (rsh >= {1'b0, m_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                op_reg   <= op;
                cnt_reg  <= CW'(WIDTH);
                acc_reg  <= '0;
                a_reg    <= opa;
                b_reg    <= opb;
                m_reg    <= modulus;
                q_reg    <= '0;
            end else if (busy_reg) begin
                unique case (op_reg)
                    MU_MUL: begin
                        acc_reg <= step2[WIDTH:0];
                    end
                    default: begin
                        if (rge) begin
                            acc_reg <= rsh - {1'b0, m_reg};
                        end else begin
                            acc_reg <= rsh;
                        end
                        q_reg <= {q_reg[WIDTH-2:0], rge};
                    end
                endcase
                b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // For reduction the dividend sits in b_reg and acc holds the remainder.
    always_comb begin
        remainder = acc_reg[WIDTH-1:0];
        if (op_reg == MU_MUL) begin
            result = acc_reg[WIDTH-1:0];
        end else begin
            result = q_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/elgamal_sign_verify_core.sv =====
// Top level of the ElGamal signature engine: registers, sequencer and result buffer.
// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        op, message, ephemeral_key, check_r, check_s
// m_        out        m_valid / m_ready        sig_r, sig_s, valid_res, key_error
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
// One item at a time; all modular arithmetic goes through the shared bit-serial unit. Verify
// takes three exponentiations and one product. Sign takes one exponentiation, an extended
// Euclid loop of division and multiply steps, and five more calls.
// Reset is synchronous and active low; configuration returns to p=3, alpha=2, d=1, beta=1.
// A result waits in the output register until taken; the next item is accepted only after.
`default_nettype none
module elgamal_sign_verify_core #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_op,
    input  wire logic [WIDTH-1:0]          s_message,
    input  wire logic [WIDTH-1:0]          s_ephemeral_key,
    input  wire logic [WIDTH-1:0]          s_check_r,
    input  wire logic [WIDTH-1:0]          s_check_s,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [WIDTH-1:0]               m_sig_r,
    output logic [WIDTH-1:0]               m_sig_s,
    output logic                           m_valid_res,
    output logic                           m_key_error,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [esv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WIDTH-1:0]          cfg_data
);
    import esv_pkg::*;

    localparam int unsigned EW = $clog2(WIDTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RED_BASE, ST_EXP_MUL, ST_EXP_SQR, ST_EXP_NEXT,
        ST_SIGN_R, ST_INV_INIT, ST_INV_DIV, ST_INV_MUL, ST_INV_SUB,
        ST_SIGN_XM, ST_SIGN_DR, ST_SIGN_S, ST_VER_2, ST_VER_3, ST_VER_MUL,
        ST_OUT
    } state_t;

    logic [WIDTH-1:0] p_reg, g_reg, d_reg, b_reg;

    state_t           state_reg;
    logic             op_reg;
    logic [WIDTH-1:0] x_reg, k_reg, cr_reg, cs_reg;
    logic [WIDTH-1:0] base_reg, exp_reg, acc_reg, mod_reg;
    logic [EW-1:0]    ebit_reg;
    logic [1:0]       phase_reg;
    logic [WIDTH-1:0] t1_reg, t2_reg;
    // Euclid state
    logic [WIDTH-1:0] or_reg, r_reg, ot_reg, t_reg, q_reg, nr_reg;

    logic             mu_start;
    mu_op_t           mu_op;
    logic [WIDTH-1:0] mu_a, mu_b, mu_m;
    logic             mu_done;
    logic [WIDTH-1:0] mu_res, mu_rem;
    logic             mu_issued_reg;

    esv_modmul #(.WIDTH(WIDTH)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mu_start), .op(mu_op),
        .opa(mu_a), .opb(mu_b), .modulus(mu_m),
        .done(mu_done), .result(mu_res), .remainder(mu_rem)
    );

    logic [WIDTH-1:0] nm1;
    assign nm1 = p_reg - 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= WIDTH'(3);
            g_reg <= WIDTH'(2);
            d_reg <= WIDTH'(1);
            b_reg <= WIDTH'(1);
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODULUS:   p_reg <= cfg_data;
                REG_GENERATOR: g_reg <= cfg_data;
                REG_PRIVATE:   d_reg <= cfg_data;
                REG_PUBLIC:    b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared unit.
    always_comb begin
        mu_op = MU_MUL;
        mu_a  = acc_reg;
        mu_b  = base_reg;
        mu_m  = mod_reg;
        unique case (state_reg)
            ST_RED_BASE: begin mu_op = MU_RED; mu_a = '0; mu_b = base_reg; end
            ST_EXP_SQR:  begin mu_a = base_reg; mu_b = base_reg; end
            ST_INV_DIV:  begin mu_op = MU_DIV; mu_a = '0; mu_b = or_reg; mu_m = r_reg; end
            ST_INV_MUL:  begin mu_a = q_reg; mu_b = t_reg; mu_m = nm1; end
            ST_SIGN_XM:  begin mu_op = MU_RED; mu_a = '0; mu_b = x_reg; mu_m = nm1; end
            ST_SIGN_DR: begin
                if (phase_reg == 2'd0) begin
                    mu_op = MU_RED;
                    mu_a  = '0;
                    mu_b  = d_reg;
                end else begin
                    mu_a = t1_reg;
                    mu_b = t2_reg;
                end
                mu_m = nm1;
            end
            ST_SIGN_S:   begin mu_a = t1_reg; mu_b = ot_reg; mu_m = nm1; end
            ST_VER_MUL:  begin mu_a = t1_reg; mu_b = t2_reg; mu_m = p_reg; end
            default: ;
        endcase
    end

    logic needs_mu;
    always_comb begin
        unique case (state_reg)
            ST_RED_BASE, ST_EXP_MUL, ST_EXP_SQR, ST_INV_DIV, ST_INV_MUL,
            ST_SIGN_XM, ST_SIGN_DR, ST_SIGN_S, ST_VER_MUL: needs_mu = 1'b1;
            default: needs_mu = 1'b0;
        endcase
    end
    assign mu_start = needs_mu && !mu_issued_reg;

    // Modular subtract helper values.
    logic [WIDTH-1:0] sub_t, sub_dr;
    assign sub_t  = (ot_reg >= mu_res) ? ot_reg - mu_res : ot_reg + (nm1 - mu_res);
    assign sub_dr = (x_reg >= mu_res) ? x_reg - mu_res : x_reg + (nm1 - mu_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid       <= 1'b0;
            mu_issued_reg <= 1'b0;
        end else begin
            if (mu_start) begin
                mu_issued_reg <= 1'b1;
            end
            if (mu_done) begin
                mu_issued_reg <= 1'b0;
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg      <= s_op;
                        x_reg       <= s_message;
                        k_reg       <= s_ephemeral_key;
                        cr_reg      <= s_check_r;
                        cs_reg      <= s_check_s;
                        m_sig_r     <= '0;
                        m_sig_s     <= '0;
                        m_valid_res <= 1'b0;
                        mod_reg     <= p_reg;
                        phase_reg   <= 2'd0;
                        if (p_reg < WIDTH'(2)) begin
                            m_key_error <= (s_op == OP_SIGN);
                            state_reg   <= ST_OUT;
                        end else begin
                            m_key_error <= 1'b0;
                            base_reg    <= g_reg;
                            exp_reg     <= (s_op == OP_SIGN) ? s_ephemeral_key : s_message;
                            state_reg   <= ST_RED_BASE;
                        end
                    end
                end
                ST_RED_BASE: begin
                    if (mu_done) begin
                        base_reg  <= mu_rem;
                        acc_reg   <= WIDTH'(1);
                        ebit_reg  <= EW'(WIDTH);
                        state_reg <= exp_reg[0] ? ST_EXP_MUL : ST_EXP_SQR;
                    end
                end
                ST_EXP_MUL: begin
                    if (mu_done) begin
                        acc_reg   <= mu_res;
                        state_reg <= ST_EXP_SQR;
                    end
                end
                ST_EXP_SQR: begin
                    if (mu_done) begin
                        base_reg  <= mu_res;
                        exp_reg   <= exp_reg >> 1;
                        ebit_reg  <= ebit_reg - 1'b1;
                        state_reg <= ST_EXP_NEXT;
                    end
                end
                ST_EXP_NEXT: begin
                    if (ebit_reg == '0) begin
                        if (op_reg == OP_SIGN) begin
                            state_reg <= ST_SIGN_R;
                        end else begin
                            state_reg <= ST_VER_2;
                        end
                    end else begin
                        state_reg <= exp_reg[0] ? ST_EXP_MUL : ST_EXP_SQR;
                    end
                end
                ST_SIGN_R: begin
                    m_sig_r   <= acc_reg;
                    t2_reg    <= acc_reg;
                    state_reg <= ST_INV_INIT;
                end
                ST_INV_INIT: begin
                    // Divide k by p-1 to obtain k mod (p-1) as the remainder.
                    or_reg    <= k_reg;
                    r_reg     <= nm1;
                    phase_reg <= 2'd1;
                    state_reg <= ST_INV_DIV;
                end
                ST_INV_DIV: begin
                    if (mu_done) begin
                        if (phase_reg == 2'd1) begin
                            or_reg    <= nm1;
                            r_reg     <= mu_rem;
                            ot_reg    <= '0;
                            t_reg     <= (nm1 == WIDTH'(1)) ? '0 : WIDTH'(1);
                            phase_reg <= 2'd2;
                            state_reg <= (mu_rem == '0) ? ST_INV_SUB : ST_INV_DIV;
                        end else begin
                            q_reg     <= mu_res;
                            nr_reg    <= mu_rem;
                            state_reg <= ST_INV_MUL;
                        end
                    end
                end
                ST_INV_MUL: begin
                    if (mu_done) begin
                        or_reg    <= r_reg;
                        r_reg     <= nr_reg;
                        ot_reg    <= t_reg;
                        t_reg     <= sub_t;
                        state_reg <= (nr_reg == '0) ? ST_INV_SUB : ST_INV_DIV;
                    end
                end
                ST_INV_SUB: begin
                    if (or_reg != WIDTH'(1)) begin
                        m_key_error <= 1'b1;
                        state_reg   <= ST_OUT;
                    end else begin
                        state_reg <= ST_SIGN_XM;
                    end
                end
                ST_SIGN_XM: begin
                    if (mu_done) begin
                        t1_reg    <= mu_rem;
                        phase_reg <= 2'd0;
                        state_reg <= ST_SIGN_DR;
                    end
                end
                ST_SIGN_DR: begin
                    // First pass reduces d mod (p-1), second forms d*r and subtracts it from x mod (p-1).
                    if (mu_done) begin
                        if (phase_reg == 2'd0) begin
                            x_reg     <= t1_reg;
                            t1_reg    <= mu_rem;
                            phase_reg <= 2'd3;
                        end else begin
                            t1_reg    <= sub_dr;
                            state_reg <= ST_SIGN_S;
                        end
                    end
                end
                ST_SIGN_S: begin
                    if (mu_done) begin
                        m_sig_s   <= mu_res;
                        state_reg <= ST_OUT;
                    end
                end
                ST_VER_2: begin
                    t1_reg    <= acc_reg;
                    base_reg  <= (phase_reg == 2'd0) ? b_reg : cr_reg;
                    exp_reg   <= (phase_reg == 2'd0) ? cr_reg : cs_reg;
                    if (phase_reg == 2'd1) begin
                        t2_reg <= acc_reg;
                    end
                    if (phase_reg == 2'd2) begin
                        t2_reg <= acc_reg;
                        state_reg <= ST_VER_3;
                    end else begin
                        if (phase_reg == 2'd0) begin
                            x_reg <= acc_reg;
                        end else begin
                            k_reg <= acc_reg;
                        end
                        phase_reg <= phase_reg + 1'b1;
                        state_reg <= ST_RED_BASE;
                    end
                end
                ST_VER_3: begin
                    t1_reg    <= k_reg;
                    state_reg <= ST_VER_MUL;
                end
                ST_VER_MUL: begin
                    if (mu_done) begin
                        m_valid_res <= (mu_res == x_reg);
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    m_valid   <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== dv/elgamal_sign_verify_core_test.sv =====
// Self-checking testbench for the ElGamal signature engine: directed and random sign/verify runs.
`default_nettype none
module elgamal_sign_verify_core_test;
    import esv_pkg::*;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned MAX_WAIT = 18;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [WIDTH-1:0] sig_r;
        logic [WIDTH-1:0] sig_s;
        logic             valid_res;
        logic             key_error;
    } sig_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_op = OP_SIGN;
    logic [WIDTH-1:0] s_message = '0;
    logic [WIDTH-1:0] s_ephemeral_key = '0;
    logic [WIDTH-1:0] s_check_r = '0;
    logic [WIDTH-1:0] s_check_s = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [WIDTH-1:0] m_sig_r;
    logic [WIDTH-1:0] m_sig_s;
    logic             m_valid_res;
    logic             m_key_error;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
    logic [WIDTH-1:0] cfg_data = '0;

    // Local copy of the engine's configuration registers.
    logic [WIDTH-1:0] cur_p = 3;
    logic [WIDTH-1:0] cur_alpha = 2;
    logic [WIDTH-1:0] cur_d = 1;
    logic [WIDTH-1:0] cur_beta = 1;

    sig_result_t pending_sigs[$];
    int unsigned error_count = 0;
    bit          no_idle = 1'b0;
    int unsigned taken_count = 0;
    int unsigned seen_count = 0;
    int unsigned recv_stall = 0;

    elgamal_sign_verify_core #(.WIDTH(WIDTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_message(s_message), .s_ephemeral_key(s_ephemeral_key),
        .s_check_r(s_check_r), .s_check_s(s_check_s),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sig_r(m_sig_r), .m_sig_s(m_sig_s),
        .m_valid_res(m_valid_res), .m_key_error(m_key_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a % m} * {64'd0, b % m};
        return 64'(prod % {64'd0, m});
    endfunction

    // Right-to-left square and multiply; m must be at least two.
    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1;
        base = base % m;
        while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Extended Euclid with the cofactor kept reduced mod n; returns 1 when gcd(a, n) is one.
    function automatic bit inv_mod_n(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
        logic [63:0] r0, r1, t0, t1, q, nr, nt;
        r0 = n;
        r1 = a % n;
        t0 = 0;
        t1 = 1 % n;
        while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1;
            nt = (t0 + n - mod_mul(q, t1, n)) % n;
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        inv = t0;
        return r0 == 1;
    endfunction

    function automatic sig_result_t predict_signature(logic op, logic [WIDTH-1:0] x,
                                                      logic [WIDTH-1:0] k,
                                                      logic [WIDTH-1:0] cr,
                                                      logic [WIDTH-1:0] cs);
        sig_result_t res;
        logic [63:0] p, n, inv, dr, diff, lhs, rhs;
        res = '0;
        p = cur_p;
        if (op == OP_SIGN) begin
            if (p < 2) begin
                res.key_error = 1'b1;
            end else begin
                n = p - 1;
                res.sig_r = WIDTH'(mod_pow(cur_alpha, k, p));
                if (inv_mod_n(k, n, inv)) begin
                    dr = mod_mul(cur_d, res.sig_r, n);
                    diff = ((x % n) + n - dr) % n;
                    res.sig_s = WIDTH'(mod_mul(diff, inv, n));
                end else begin
                    res.key_error = 1'b1;
                end
            end
        end else if (p >= 2) begin
            lhs = mod_pow(cur_alpha, x, p);
            rhs = mod_mul(mod_pow(cur_beta, cr, p), mod_pow(cr, cs, p), p);
            res.valid_res = (lhs == rhs);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [WIDTH-1:0] got, logic [WIDTH-1:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Result checker: each transaction on m_ is compared with the oldest prediction.
    always @(posedge aclk) begin
        sig_result_t want;
        if (aresetn && m_valid && m_ready) begin
            taken_count++;
            if (pending_sigs.size() == 0) begin
                report_mismatch("unexpected result r", m_sig_r, '0);
            end else begin
                want = pending_sigs.pop_front();
                if (m_sig_r !== want.sig_r) report_mismatch("sig_r", m_sig_r, want.sig_r);
                if (m_sig_s !== want.sig_s) report_mismatch("sig_s", m_sig_s, want.sig_s);
                if (m_valid_res !== want.valid_res)
                    report_mismatch("valid_res", WIDTH'(m_valid_res), WIDTH'(want.valid_res));
                if (m_key_error !== want.key_error)
                    report_mismatch("key_error", WIDTH'(m_key_error), WIDTH'(want.key_error));
            end
        end
    end

    // Receiver back-pressure: a fresh stall is drawn after every result.
    always @(negedge aclk) begin
        if (taken_count != seen_count) begin
            seen_count = taken_count;
            recv_stall = draw_wait();
        end
        if (recv_stall > 0) begin
            m_ready <= 1'b0;
            recv_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(logic op, logic [WIDTH-1:0] x, logic [WIDTH-1:0] k,
                             logic [WIDTH-1:0] cr, logic [WIDTH-1:0] cs);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_message = x;
        s_ephemeral_key = k;
        s_check_r = cr;
        s_check_s = cs;
        do @(posedge aclk); while (!s_ready);
        pending_sigs.push_back(predict_signature(op, x, k, cr, cs));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_sigs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [WIDTH-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODULUS:   cur_p = value;
            REG_GENERATOR: cur_alpha = value;
            REG_PRIVATE:   cur_d = value;
            REG_PUBLIC:    cur_beta = value;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_keys(logic [WIDTH-1:0] p, logic [WIDTH-1:0] alpha,
                            logic [WIDTH-1:0] d, logic [WIDTH-1:0] beta);
        wait_idle();
        write_reg(REG_MODULUS, p);
        write_reg(REG_GENERATOR, alpha);
        write_reg(REG_PRIVATE, d);
        write_reg(REG_PUBLIC, beta);
    endtask

    task automatic test_reset_values();
        send_item(OP_SIGN, 32'd5, 32'd1, '0, '0);
        send_item(OP_SIGN, 32'd5, 32'd2, '0, '0);
        send_item(OP_VERIFY, 32'd1, '0, 32'd2, 32'd1);
    endtask

    task automatic test_degenerate_modulus();
        set_keys(32'd0, 32'd2, 32'd1, 32'd1);
        send_item(OP_SIGN, 32'd7, 32'd3, '0, '0);
        send_item(OP_VERIFY, 32'd7, '0, 32'd3, 32'd3);
        set_keys(32'd1, 32'd0, 32'd0, 32'd0);
        send_item(OP_SIGN, '1, '1, '1, '1);
        send_item(OP_VERIFY, '1, '1, '1, '1);
        // With p = 2 every k counts as invertible and s is always zero.
        set_keys(32'd2, 32'd1, 32'd1, 32'd1);
        send_item(OP_SIGN, '1, '1, '0, '0);
        send_item(OP_VERIFY, 32'd3, '0, 32'd1, 32'd9);
    endtask

    task automatic test_field_extremes();
        logic [WIDTH-1:0] p;
        sig_result_t sig;
        p = 32'hFFFF_FFFB;
        set_keys(p, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(mod_pow(32'hFFFF_FFFF, 32'hFFFF_FFFF, p)));
        send_item(OP_SIGN, '0, '0, '0, '0);
        send_item(OP_SIGN, '1, p - 1, '0, '0);
        send_item(OP_SIGN, '1, '1, '0, '0);
        send_item(OP_SIGN, 32'h1234_5678, 32'd1, '1, '1);
        sig = predict_signature(OP_SIGN, 32'hDEAD_BEEF, 32'd7, '0, '0);
        send_item(OP_SIGN, 32'hDEAD_BEEF, 32'd7, '0, '0);
        send_item(OP_VERIFY, 32'hDEAD_BEEF, '1, sig.sig_r, sig.sig_s);
        send_item(OP_VERIFY, 32'hDEAD_BEEE, '0, sig.sig_r, sig.sig_s);
        send_item(OP_VERIFY, '1, '0, '1, '1);
        send_item(OP_VERIFY, '0, '0, '0, '0);
        send_item(OP_VERIFY, '0, '0, p, '0);
    endtask

    task automatic choose_random_keys();
        logic [WIDTH-1:0] primes[8] = '{32'd3, 32'd5, 32'd11, 32'd467, 32'd65521,
                                         32'd2147483647, 32'hFFFF_FFFB, 32'd1000003};
        logic [WIDTH-1:0] p, alpha, d, beta;
        p = primes[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) == 0) p = $urandom();
        alpha = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(2, 1000);
        d = $urandom();
        beta = (p >= 2 && $urandom_range(0, 5) != 0) ? 32'(mod_pow(alpha, d, p)) : $urandom();
        set_keys(p, alpha, d, beta);
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        logic [WIDTH-1:0] x, k;
        sig_result_t sig;
        int unsigned pick;
        sent = 0;
        while (sent < 121) begin
            if (sent % 20 == 0) begin
                choose_random_keys();
                no_idle = ($urandom_range(0, 3) == 0);
            end
            // Hold the sender until the engine has drained once.
            if (sent == 60) wait_idle();
            x = $urandom();
            k = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_item(OP_SIGN, x, k, $urandom(), $urandom());
            end else if (pick < 75) begin
                // Verify of a predicted signature, with one message bit flipped for pick >= 65.
                sig = predict_signature(OP_SIGN, x, k, '0, '0);
                if (pick >= 65) x = x ^ (32'd1 << $urandom_range(0, WIDTH - 1));
                send_item(OP_VERIFY, x, $urandom(), sig.sig_r, sig.sig_s);
            end else begin
                send_item(1'($urandom_range(0, 1)), x, k, $urandom(), $urandom());
            end
            sent++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_values();
        test_degenerate_modulus();
        test_field_extremes();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_sigs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("ERROR: timeout with %0d results outstanding", pending_sigs.size());
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
